### rtl/tfhe_pkg.sv
package tfhe_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [15:0] TYPE_V4   = 16'h0800;
  localparam logic [15:0] TYPE_V6   = 16'h86dd;
  localparam logic [12:0] FRAG_MASK = 13'h1fff;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [3:0]  IP_VER4   = 4'd4;
  localparam logic [3:0]  IHL_MIN   = 4'd5;

  // Byte offsets within the frame.
  localparam int POS_TYPE_HI   = 12;
  localparam int POS_TYPE_LO   = 13;
  localparam int POS_IP_START  = 14;
  localparam int POS_V4_FRAG_HI = 20;
  localparam int POS_V4_FRAG_LO = 21;
  localparam int POS_V4_PROTO  = 23;
  localparam int POS_V4_SRC    = 26;
  localparam int POS_V4_DST    = 30;
  localparam int POS_V4_END    = 34;
  localparam int POS_V6_NEXT   = 20;
  localparam int POS_V6_ADDR   = 22;
  localparam int POS_V6_TCP    = 54;
  localparam int TCP_SPAN      = 12;
  localparam int MIN_LEN       = 34;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tfhe_byte_t;

  typedef struct packed {
    logic        accepted;
    logic        is_ipv6;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] acknowledge_number;
  } tfhe_res_t;

endpackage

### rtl/tfhe_if.sv
interface tfhe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfhe_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        is_ipv6;
  logic [63:0] source_addr_high;
  logic [63:0] source_addr_low;
  logic [63:0] dest_addr_high;
  logic [63:0] dest_addr_low;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] sequence_number;
  logic [31:0] acknowledge_number;

  modport source (
    output valid, output accepted, output is_ipv6,
    output source_addr_high, output source_addr_low,
    output dest_addr_high, output dest_addr_low,
    output source_port, output dest_port,
    output sequence_number, output acknowledge_number,
    input ready
  );
  modport sink (
    input valid, input accepted, input is_ipv6,
    input source_addr_high, input source_addr_low,
    input dest_addr_high, input dest_addr_low,
    input source_port, input dest_port,
    input sequence_number, input acknowledge_number,
    output ready
  );
endinterface

### rtl/tcp_frame_header_extractor_unit.sv
// Parses an Ethernet frame delivered one byte per request, in wire order, with the final
// byte marked, and gives one result request per frame: whether it is a TCP segment over
// IPv4 (version 4, IHL of at least 5, no fragment offset, protocol 6) or IPv6 (next header
// 6), and if so its addresses, ports, sequence and acknowledgement numbers; a rejected
// frame gives all fields zero. Frames shorter than 34 bytes or ending before the last
// acknowledgement byte are rejected. The block takes one byte every cycle while not stalled;
// each byte is held in the input register and then updates the frame state, and the result is
// registered in the output register as the final byte leaves the input register. Only a
// frame-end byte whose result cannot enter a still occupied output register stalls input.
// COUNT_BITS sizes the saturating byte counter.
module tcp_frame_header_extractor_unit
  import tfhe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  tfhe_in_if.sink        in_ch,
  tfhe_out_if.source     out_ch
);

  tfhe_byte_t in_item, cur_item;
  tfhe_res_t  res, out_res;
  logic       step, out_free, in_ready;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;
  assign in_ch.ready       = in_ready;

  tfhe_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_free (out_free),
    .step     (step),
    .cur_item (cur_item)
  );

  tfhe_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cur_item (cur_item),
    .res      (res)
  );

  tfhe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && cur_item.last_byte),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.accepted           = out_res.accepted;
  assign out_ch.is_ipv6            = out_res.is_ipv6;
  assign out_ch.source_addr_high   = out_res.source_addr_high;
  assign out_ch.source_addr_low    = out_res.source_addr_low;
  assign out_ch.dest_addr_high     = out_res.dest_addr_high;
  assign out_ch.dest_addr_low      = out_res.dest_addr_low;
  assign out_ch.source_port        = out_res.source_port;
  assign out_ch.dest_port          = out_res.dest_port;
  assign out_ch.sequence_number    = out_res.sequence_number;
  assign out_ch.acknowledge_number = out_res.acknowledge_number;

endmodule

### rtl/tfhe_in_reg.sv
module tfhe_in_reg
  import tfhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tfhe_byte_t in_item,
  input  logic       out_free,
  output logic       step,
  output tfhe_byte_t cur_item
);

  logic       vld_r;
  tfhe_byte_t item_r;

  // A frame-end byte waits here until the result register can take its result.
  assign step     = vld_r && (!item_r.last_byte || out_free);
  assign in_ready = !vld_r || step;
  assign cur_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (step) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/tfhe_parser.sv
module tfhe_parser
  import tfhe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  tfhe_byte_t cur_item,
  output tfhe_res_t  res
);

  localparam logic [COUNT_BITS-1:0] POS_MAX = '1;

  logic [COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]           ftype_r, ftype_nxt;
  logic [3:0]            ihl_r, ihl_nxt;
  logic                  rej_r, rej_nxt;
  logic [4:0]            frag_hi_r, frag_hi_nxt;
  logic [63:0]           addr_r [4];
  logic [63:0]           addr_nxt [4];
  logic [15:0]           port_r [2];
  logic [15:0]           port_nxt [2];
  logic [31:0]           seq_r [2];
  logic [31:0]           seq_nxt [2];

  logic [7:0]            b;
  logic                  is_v4, is_v6;
  logic [COUNT_BITS-1:0] tcp_start, rel_full, v6_off, need_m1;
  logic                  tcp_hit;
  logic [3:0]            rel;
  logic [1:0]            addr_k;
  logic                  frame_ok, v6_end;

  function automatic logic [COUNT_BITS-1:0] at(input int v);
    return COUNT_BITS'(v);
  endfunction

  always_comb begin
    b           = cur_item.data_byte;
    pos_nxt     = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    ftype_nxt   = ftype_r;
    ihl_nxt     = ihl_r;
    rej_nxt     = rej_r;
    frag_hi_nxt = frag_hi_r;
    addr_nxt    = addr_r;
    port_nxt    = port_r;
    seq_nxt     = seq_r;
    tcp_hit     = 1'b0;
    rel_full    = '0;
    v6_off      = pos_r - at(POS_V6_ADDR);
    addr_k      = v6_off[4:3];
    tcp_start   = at(POS_IP_START) + {{(COUNT_BITS-6){1'b0}}, ihl_r, 2'b00};

    is_v4 = (ftype_r == TYPE_V4) && (pos_r >= at(POS_IP_START));
    is_v6 = (ftype_r == TYPE_V6) && (pos_r >= at(POS_IP_START));

    if (pos_r == at(POS_TYPE_HI) || pos_r == at(POS_TYPE_LO)) begin
      ftype_nxt = {ftype_r[7:0], b};
    end

    if (is_v4) begin
      if (pos_r == at(POS_IP_START)) begin
        ihl_nxt = b[3:0];
        if (b[7:4] != IP_VER4 || b[3:0] < IHL_MIN) begin
          rej_nxt = 1'b1;
        end
      end else if (pos_r == at(POS_V4_FRAG_HI)) begin
        frag_hi_nxt = b[4:0];
      end else if (pos_r == at(POS_V4_FRAG_LO)) begin
        if (({frag_hi_r, b} & FRAG_MASK) != 13'd0) begin
          rej_nxt = 1'b1;
        end
      end else if (pos_r == at(POS_V4_PROTO)) begin
        if (b != PROTO_TCP) begin
          rej_nxt = 1'b1;
        end
      end else if (pos_r >= at(POS_V4_SRC) && pos_r < at(POS_V4_DST)) begin
        addr_nxt[1] = {addr_r[1][55:0], b};
      end else if (pos_r >= at(POS_V4_DST) && pos_r < at(POS_V4_END)) begin
        addr_nxt[3] = {addr_r[3][55:0], b};
      end
      // The IHL register still reads zero on the version byte, so no
      // segment byte can match there.
      if (ihl_r >= IHL_MIN && pos_r >= tcp_start && pos_r < tcp_start + at(TCP_SPAN)) begin
        tcp_hit  = 1'b1;
        rel_full = pos_r - tcp_start;
      end
    end else if (is_v6) begin
      if (pos_r == at(POS_V6_NEXT)) begin
        if (b != PROTO_TCP) begin
          rej_nxt = 1'b1;
        end
      end else if (pos_r >= at(POS_V6_ADDR) && pos_r < at(POS_V6_TCP)) begin
        addr_nxt[addr_k] = {addr_r[addr_k][55:0], b};
      end else if (pos_r >= at(POS_V6_TCP) && pos_r < at(POS_V6_TCP + TCP_SPAN)) begin
        tcp_hit  = 1'b1;
        rel_full = pos_r - at(POS_V6_TCP);
      end
    end

    rel = rel_full[3:0];
    if (tcp_hit) begin
      if (rel < 4'd2) begin
        port_nxt[0] = {port_r[0][7:0], b};
      end else if (rel < 4'd4) begin
        port_nxt[1] = {port_r[1][7:0], b};
      end else if (rel < 4'd8) begin
        seq_nxt[0] = {seq_r[0][23:0], b};
      end else begin
        seq_nxt[1] = {seq_r[1][23:0], b};
      end
    end

    // The frame must reach the last byte of the acknowledgement field.
    v6_end   = (ftype_nxt == TYPE_V6);
    need_m1  = v6_end ? at(POS_V6_TCP + TCP_SPAN - 1)
                      : at(POS_IP_START + TCP_SPAN - 1)
                        + {{(COUNT_BITS-6){1'b0}}, ihl_nxt, 2'b00};
    frame_ok = !rej_nxt && (ftype_nxt == TYPE_V4 || v6_end)
               && pos_r >= at(MIN_LEN - 1) && pos_r >= need_m1;

    res = '0;
    if (frame_ok) begin
      res.accepted           = 1'b1;
      res.is_ipv6            = v6_end;
      res.source_addr_high   = addr_nxt[0];
      res.source_addr_low    = addr_nxt[1];
      res.dest_addr_high     = addr_nxt[2];
      res.dest_addr_low      = addr_nxt[3];
      res.source_port        = port_nxt[0];
      res.dest_port          = port_nxt[1];
      res.sequence_number    = seq_nxt[0];
      res.acknowledge_number = seq_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && cur_item.last_byte)) begin
      pos_r     <= '0;
      ftype_r   <= '0;
      ihl_r     <= '0;
      rej_r     <= 1'b0;
      frag_hi_r <= '0;
      for (int i = 0; i < 4; i++) begin
        addr_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        port_r[i] <= '0;
        seq_r[i]  <= '0;
      end
    end else if (step) begin
      pos_r     <= pos_nxt;
      ftype_r   <= ftype_nxt;
      ihl_r     <= ihl_nxt;
      rej_r     <= rej_nxt;
      frag_hi_r <= frag_hi_nxt;
      addr_r    <= addr_nxt;
      port_r    <= port_nxt;
      seq_r     <= seq_nxt;
    end
  end

endmodule

### rtl/tfhe_out_reg.sv
module tfhe_out_reg
  import tfhe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  tfhe_res_t res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_ready,
  output tfhe_res_t out_res
);

  logic      vld_r;
  tfhe_res_t res_r;

  assign out_free  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
